>>> hdl/imuctf_pkg.sv
`timescale 1ns / 1ps

package imuctf_pkg;

   // Default working width and fraction bits of the fixed-point datapath
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 15;

   // Port geometry
   localparam int FIELD_WIDTH    = 32;
   localparam int REQ_FIELDS     = 5;
   localparam int REQ_DATA_WIDTH = FIELD_WIDTH * REQ_FIELDS;
   localparam int RSP_DATA_WIDTH = FIELD_WIDTH * 2;
   localparam int RSP_USER_WIDTH = 1;

   // Configuration registers
   localparam int CFG_WIDTH      = 22;
   localparam int GAIN_WIDTH     = 16;
   localparam int CSR_ADDR_WIDTH = 2;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_RAD_TO_DEG   = 2'd0,
      CSR_GYRO_STEP    = 2'd1,
      CSR_BLEND        = 2'd2,
      CSR_ACCEL_WEIGHT = 2'd3
   } csr_index_type;

   localparam logic [CFG_WIDTH-1:0]  RST_RAD_TO_DEG   = 22'd1877468;
   localparam logic [GAIN_WIDTH-1:0] RST_GYRO_STEP    = 16'd33;
   localparam logic [GAIN_WIDTH-1:0] RST_BLEND        = 16'd32735;
   localparam logic [GAIN_WIDTH-1:0] RST_ACCEL_WEIGHT = 16'd33;

   // Microcode
   localparam int UPC_WIDTH     = 5;
   localparam int UPC_DIV_WAIT  = 11;
   localparam int UPC_TILT_WGT  = 19;
   localparam int UPC_DONE      = 25;

   typedef enum logic [2:0] {
      UOP_NOP,
      UOP_DIV,   // launch both tilt divisions
      UOP_MLO,   // low half partial product into accumulator
      UOP_MHI,   // high half partial product, scale, write back
      UOP_ADD,
      UOP_SUB,
      UOP_SAT,   // saturated tilt for a zero divisor
      UOP_DONE   // post result, return to idle
   } uop_type;

   typedef enum logic [3:0] {
      RS_AX, RS_AY, RS_GX, RS_GY,
      RS_QX, RS_QY,
      RS_TX, RS_TY, RS_DX, RS_DY, RS_FX, RS_FY
   } reg_sel_type;

   typedef enum logic [1:0] {
      KS_R2D, KS_GSTEP, KS_BLEND, KS_AWGT
   } kon_sel_type;

   typedef enum logic [1:0] {
      JC_NEVER, JC_DIV_BUSY, JC_NONZERO, JC_OUT_FULL
   } jcond_type;

   typedef struct packed {
      uop_type                op;
      reg_sel_type            a;
      reg_sel_type            b;
      kon_sel_type            k;
      reg_sel_type            dst;
      jcond_type              jc;
      logic [UPC_WIDTH-1:0]   target;
   } ucode_type;

   function automatic ucode_type uw(input uop_type op, input reg_sel_type a,
                                    input reg_sel_type b, input kon_sel_type k,
                                    input reg_sel_type dst, input jcond_type jc,
                                    input int unsigned tgt);
      ucode_type w;
      w.op     = op;
      w.a      = a;
      w.b      = b;
      w.k      = k;
      w.dst    = dst;
      w.jc     = jc;
      w.target = UPC_WIDTH'(tgt);
      return w;
   endfunction

   // Control store: one word per step; a taken jump suppresses the step's op
   function automatic ucode_type ucode_rom(input int unsigned addr);
      ucode_type w;
      case (addr)
         0:  w = uw(UOP_DIV,  RS_AX, RS_AX, KS_R2D,   RS_AX, JC_NEVER,    0);
         1:  w = uw(UOP_MLO,  RS_GX, RS_AX, KS_GSTEP, RS_AX, JC_NEVER,    0);
         2:  w = uw(UOP_MHI,  RS_GX, RS_AX, KS_GSTEP, RS_DX, JC_NEVER,    0);
         3:  w = uw(UOP_MLO,  RS_GY, RS_AX, KS_GSTEP, RS_AX, JC_NEVER,    0);
         4:  w = uw(UOP_MHI,  RS_GY, RS_AX, KS_GSTEP, RS_DY, JC_NEVER,    0);
         5:  w = uw(UOP_SUB,  RS_FX, RS_DX, KS_R2D,   RS_DX, JC_NEVER,    0);
         6:  w = uw(UOP_ADD,  RS_FY, RS_DY, KS_R2D,   RS_DY, JC_NEVER,    0);
         7:  w = uw(UOP_MLO,  RS_DX, RS_AX, KS_BLEND, RS_AX, JC_NEVER,    0);
         8:  w = uw(UOP_MHI,  RS_DX, RS_AX, KS_BLEND, RS_DX, JC_NEVER,    0);
         9:  w = uw(UOP_MLO,  RS_DY, RS_AX, KS_BLEND, RS_AX, JC_NEVER,    0);
         10: w = uw(UOP_MHI,  RS_DY, RS_AX, KS_BLEND, RS_DY, JC_NEVER,    0);
         11: w = uw(UOP_NOP,  RS_AX, RS_AX, KS_R2D,   RS_AX, JC_DIV_BUSY, UPC_DIV_WAIT);
         12: w = uw(UOP_MLO,  RS_QX, RS_AX, KS_R2D,   RS_AX, JC_NEVER,    0);
         13: w = uw(UOP_MHI,  RS_QX, RS_AX, KS_R2D,   RS_TX, JC_NEVER,    0);
         14: w = uw(UOP_MLO,  RS_QY, RS_AX, KS_R2D,   RS_AX, JC_NEVER,    0);
         15: w = uw(UOP_MHI,  RS_QY, RS_AX, KS_R2D,   RS_TY, JC_NEVER,    0);
         16: w = uw(UOP_NOP,  RS_AX, RS_AX, KS_R2D,   RS_AX, JC_NONZERO,  UPC_TILT_WGT);
         17: w = uw(UOP_SAT,  RS_AY, RS_AX, KS_R2D,   RS_TX, JC_NEVER,    0);
         18: w = uw(UOP_SAT,  RS_AX, RS_AX, KS_R2D,   RS_TY, JC_NEVER,    0);
         19: w = uw(UOP_MLO,  RS_TX, RS_AX, KS_AWGT,  RS_AX, JC_NEVER,    0);
         20: w = uw(UOP_MHI,  RS_TX, RS_AX, KS_AWGT,  RS_TX, JC_NEVER,    0);
         21: w = uw(UOP_MLO,  RS_TY, RS_AX, KS_AWGT,  RS_AX, JC_NEVER,    0);
         22: w = uw(UOP_MHI,  RS_TY, RS_AX, KS_AWGT,  RS_TY, JC_NEVER,    0);
         23: w = uw(UOP_SUB,  RS_DX, RS_TX, KS_R2D,   RS_FX, JC_NEVER,    0);
         24: w = uw(UOP_SUB,  RS_DY, RS_TY, KS_R2D,   RS_FY, JC_NEVER,    0);
         25: w = uw(UOP_DONE, RS_AX, RS_AX, KS_R2D,   RS_AX, JC_OUT_FULL, UPC_DONE);
         default: w = uw(UOP_DONE, RS_AX, RS_AX, KS_R2D, RS_AX, JC_OUT_FULL, UPC_DONE);
      endcase
      return w;
   endfunction

endpackage

>>> hdl/imuctf_div.sv
`timescale 1ns / 1ps

// Two-lane restoring divider, shared divisor: quot = (num << FRAC_BITS) / den,
// truncated toward zero, wrapped to DATA_WIDTH bits.
module imuctf_div #(
   parameter int DATA_WIDTH = imuctf_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = imuctf_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DATA_WIDTH-1:0] num_x,
   input  logic signed [DATA_WIDTH-1:0] num_y,
   input  logic signed [DATA_WIDTH-1:0] den,
   output logic                         busy,
   output logic signed [DATA_WIDTH-1:0] quot_x,
   output logic signed [DATA_WIDTH-1:0] quot_y
);

   localparam int DW = DATA_WIDTH + FRAC_BITS;
   localparam int CW = $clog2(DW + 2);

   logic                  busy_ff;
   logic [CW-1:0]         cnt_ff;
   logic [DATA_WIDTH-1:0] ub_ff;
   logic [DATA_WIDTH-1:0] rem_ff [2];
   logic [DW-1:0]         dq_ff  [2];
   logic                  neg_ff [2];

   logic signed [DATA_WIDTH-1:0] num_sel [2];
   logic [DATA_WIDTH-1:0]        rem_in  [2];
   logic                         qbit    [2];
   logic [DATA_WIDTH:0]          part    [2];
   logic [DATA_WIDTH+1:0]        diff    [2];
   logic                         last_step;

   assign num_sel[0] = num_x;
   assign num_sel[1] = num_y;
   assign last_step  = (cnt_ff == CW'(DW));

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         part[l]   = {rem_ff[l], dq_ff[l][DW-1]};
         diff[l]   = {1'b0, part[l]} - {2'b00, ub_ff};
         qbit[l]   = !diff[l][DATA_WIDTH+1];
         rem_in[l] = qbit[l] ? diff[l][DATA_WIDTH-1:0] : part[l][DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         // one quotient bit per lane each cycle, then a final step fixes the sign
         if (last_step) busy_ff <= 1'b0;
         else           cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ub_ff <= den[DATA_WIDTH-1] ? DATA_WIDTH'(-den) : den;
         for (int l = 0; l < 2; l++) begin
            rem_ff[l] <= '0;
            neg_ff[l] <= num_sel[l][DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
            dq_ff[l]  <= {(num_sel[l][DATA_WIDTH-1] ? DATA_WIDTH'(-num_sel[l]) : num_sel[l]),
                          {FRAC_BITS{1'b0}}};
         end
      end else if (busy_ff) begin
         for (int l = 0; l < 2; l++) begin
            if (last_step) begin
               if (neg_ff[l]) dq_ff[l][DATA_WIDTH-1:0] <= -dq_ff[l][DATA_WIDTH-1:0];
            end else begin
               rem_ff[l] <= rem_in[l];
               dq_ff[l]  <= {dq_ff[l][DW-2:0], qbit[l]};
            end
         end
      end
   end

   assign busy   = busy_ff;
   assign quot_x = dq_ff[0][DATA_WIDTH-1:0];
   assign quot_y = dq_ff[1][DATA_WIDTH-1:0];

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_full_run: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> ($past(cnt_ff) == CW'(DW)))
      else $error("divider finished before all quotient bits");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff <= CW'(DW)))
      else $error("divider step count out of range");

endmodule

>>> hdl/imu_complementary_tilt_filter_top.sv
`timescale 1ns / 1ps

// Two-axis complementary tilt filter. Each req word carries one inertial sample
// (three accelerations, two rotation rates, signed fixed point with FRAC_BITS
// fraction bits) and yields one rsp word with the updated x and y angles and a
// flag that accel_z was zero, in which case both accelerometer tilts saturate
// by the numerator's sign (a zero numerator gives zero). A small microprogram
// in a control ROM steps a shared datapath: one split multiplier (two steps per
// fixed-point multiply) and a two-lane bit-serial divider that forms both tilt
// ratios at once. The divider yields one quotient bit per cycle, with the gyro
// terms worked out while it runs. A word is taken only after the last one has
// posted its result; that result sits in an output register, so the next word
// is taken while it waits, and a second result waits on the last microstep
// until the first is taken. Configuration writes land at once and are meant
// only while the block is idle.
module imu_complementary_tilt_filter_top #(
   parameter int DATA_WIDTH = imuctf_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = imuctf_pkg::FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // req_tdata, low bit up: accel_x, accel_y, accel_z, gyro_x, gyro_y (32 each)
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [imuctf_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // rsp_tdata, low bit up: angle_x, angle_y (32 each)
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [imuctf_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // rsp_tuser, low bit up: zero_divisor
   output logic [imuctf_pkg::RSP_USER_WIDTH-1:0]   rsp_tuser,
   input  logic                                    csr_we,
   input  logic [imuctf_pkg::CSR_ADDR_WIDTH-1:0]   csr_addr,
   input  logic [imuctf_pkg::CFG_WIDTH-1:0]        csr_wdata
);

   import imuctf_pkg::*;

   localparam int HALF = DATA_WIDTH / 2;
   localparam int MAW  = DATA_WIDTH - HALF + 1;       // multiplier a operand
   localparam int MPW  = MAW + CFG_WIDTH + 1;         // multiplier product
   localparam int PW   = DATA_WIDTH + CFG_WIDTH + 2;  // full product

   typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_type;

   // Sequencer and output register
   seq_state_type          seq_state_ff;
   logic [UPC_WIDTH-1:0]   upc_ff;
   logic [UPC_WIDTH-1:0]   upc_in;
   ucode_type              ucw;
   logic                   rsp_tvalid_ff;
   logic [FIELD_WIDTH-1:0] angle_x_ff;
   logic [FIELD_WIDTH-1:0] angle_y_ff;
   logic                   zero_div_ff;

   // Configuration
   logic [CFG_WIDTH-1:0]  rad_to_deg_ff;
   logic [GAIN_WIDTH-1:0] gyro_step_ff;
   logic [GAIN_WIDTH-1:0] blend_ff;
   logic [GAIN_WIDTH-1:0] accel_weight_ff;

   // Datapath registers
   logic signed [DATA_WIDTH-1:0] ax_ff, ay_ff, az_ff, gx_ff, gy_ff;
   logic signed [DATA_WIDTH-1:0] tx_ff, ty_ff, dx_ff, dy_ff;
   logic signed [DATA_WIDTH-1:0] fx_ff, fy_ff;
   logic [PW-1:0]                acc_ff;

   logic                         req_accept;
   logic                         az_nonzero;
   logic                         jump_take;
   logic                         step_go;
   logic                         wr_en;
   logic signed [DATA_WIDTH-1:0] a_val, b_val, sat_val, res_val;
   logic [CFG_WIDTH-1:0]         k_val;
   logic signed [MAW-1:0]        mul_a;
   logic signed [CFG_WIDTH:0]    mul_b;
   logic signed [MPW-1:0]        mul_p;
   logic [PW-1:0]                mul_ext;
   logic [PW-1:0]                prod;

   logic                         div_start;
   logic                         div_busy;
   logic signed [DATA_WIDTH-1:0] qx, qy;

   assign ucw        = ucode_rom(int'(upc_ff));
   assign req_tready = (seq_state_ff == SEQ_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign az_nonzero = (az_ff != '0);

   always_comb begin
      unique case (ucw.jc)
         JC_NEVER:    jump_take = 1'b0;
         JC_DIV_BUSY: jump_take = div_busy;
         JC_NONZERO:  jump_take = az_nonzero;
         JC_OUT_FULL: jump_take = rsp_tvalid_ff && !rsp_tready;
         default:     jump_take = 1'b0;
      endcase
   end

   assign step_go   = (seq_state_ff == SEQ_RUN) && !jump_take;
   assign div_start = step_go && (ucw.op == UOP_DIV);
   assign wr_en     = step_go && (ucw.op inside {UOP_MHI, UOP_ADD, UOP_SUB, UOP_SAT});
   assign upc_in    = jump_take ? ucw.target : upc_ff + 1'b1;

   // Operand select
   always_comb begin
      unique case (ucw.a)
         RS_AX:   a_val = ax_ff;
         RS_AY:   a_val = ay_ff;
         RS_GX:   a_val = gx_ff;
         RS_GY:   a_val = gy_ff;
         RS_QX:   a_val = qx;
         RS_QY:   a_val = qy;
         RS_TX:   a_val = tx_ff;
         RS_TY:   a_val = ty_ff;
         RS_DX:   a_val = dx_ff;
         RS_DY:   a_val = dy_ff;
         RS_FX:   a_val = fx_ff;
         RS_FY:   a_val = fy_ff;
         default: a_val = '0;
      endcase
      unique case (ucw.b)
         RS_TX:   b_val = tx_ff;
         RS_TY:   b_val = ty_ff;
         RS_DX:   b_val = dx_ff;
         RS_DY:   b_val = dy_ff;
         default: b_val = '0;
      endcase
      unique case (ucw.k)
         KS_R2D:   k_val = rad_to_deg_ff;
         KS_GSTEP: k_val = CFG_WIDTH'(gyro_step_ff);
         KS_BLEND: k_val = CFG_WIDTH'(blend_ff);
         KS_AWGT:  k_val = CFG_WIDTH'(accel_weight_ff);
         default:  k_val = '0;
      endcase
   end

   // Split multiply: unsigned low half first, signed high half on the next step
   always_comb begin
      if (ucw.op == UOP_MHI) mul_a = {a_val[DATA_WIDTH-1], a_val[DATA_WIDTH-1:HALF]};
      else                   mul_a = {{(MAW-HALF){1'b0}}, a_val[HALF-1:0]};
   end

   assign mul_b   = {1'b0, k_val};
   assign mul_p   = mul_a * mul_b;
   assign mul_ext = {{(PW-MPW){mul_p[MPW-1]}}, mul_p};
   assign prod    = acc_ff + (mul_ext << HALF);

   // Zero divisor: saturate toward the numerator's sign, zero stays zero
   always_comb begin
      if (a_val == '0)                sat_val = '0;
      else if (a_val[DATA_WIDTH-1])   sat_val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      else                            sat_val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   end

   always_comb begin
      case (ucw.op)
         UOP_MHI: res_val = prod[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS];
         UOP_ADD: res_val = a_val + b_val;
         UOP_SUB: res_val = a_val - b_val;
         UOP_SAT: res_val = sat_val;
         default: res_val = a_val;
      endcase
   end

   // Sequencer: step counter, state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff  <= SEQ_IDLE;
         upc_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready) rsp_tvalid_ff <= 1'b0;
         unique case (seq_state_ff)
            SEQ_IDLE: begin
               if (req_accept) begin
                  seq_state_ff <= SEQ_RUN;
                  upc_ff       <= '0;
               end
            end
            SEQ_RUN: begin
               if (!jump_take && ucw.op == UOP_DONE) begin
                  // post result, overrides the drop above
                  seq_state_ff  <= SEQ_IDLE;
                  rsp_tvalid_ff <= 1'b1;
                  angle_x_ff    <= FIELD_WIDTH'($unsigned(fx_ff));
                  angle_y_ff    <= FIELD_WIDTH'($unsigned(fy_ff));
                  zero_div_ff   <= !az_nonzero;
               end else begin
                  upc_ff <= upc_in;
               end
            end
            default: seq_state_ff <= SEQ_IDLE;
         endcase
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rad_to_deg_ff   <= RST_RAD_TO_DEG;
         gyro_step_ff    <= RST_GYRO_STEP;
         blend_ff        <= RST_BLEND;
         accel_weight_ff <= RST_ACCEL_WEIGHT;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_RAD_TO_DEG:   rad_to_deg_ff   <= csr_wdata;
            CSR_GYRO_STEP:    gyro_step_ff    <= csr_wdata[GAIN_WIDTH-1:0];
            CSR_BLEND:        blend_ff        <= csr_wdata[GAIN_WIDTH-1:0];
            CSR_ACCEL_WEIGHT: accel_weight_ff <= csr_wdata[GAIN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Sample and scratch registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         ax_ff <= DATA_WIDTH'($signed(req_tdata[0*FIELD_WIDTH +: FIELD_WIDTH]));
         ay_ff <= DATA_WIDTH'($signed(req_tdata[1*FIELD_WIDTH +: FIELD_WIDTH]));
         az_ff <= DATA_WIDTH'($signed(req_tdata[2*FIELD_WIDTH +: FIELD_WIDTH]));
         gx_ff <= DATA_WIDTH'($signed(req_tdata[3*FIELD_WIDTH +: FIELD_WIDTH]));
         gy_ff <= DATA_WIDTH'($signed(req_tdata[4*FIELD_WIDTH +: FIELD_WIDTH]));
      end
      if (step_go && ucw.op == UOP_MLO) acc_ff <= mul_ext;
      if (wr_en) begin
         unique case (ucw.dst)
            RS_TX:   tx_ff <= res_val;
            RS_TY:   ty_ff <= res_val;
            RS_DX:   dx_ff <= res_val;
            RS_DY:   dy_ff <= res_val;
            default: ;
         endcase
      end
   end

   // Filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         fx_ff <= '0;
         fy_ff <= '0;
      end else if (wr_en) begin
         if (ucw.dst == RS_FX) fx_ff <= res_val;
         if (ucw.dst == RS_FY) fy_ff <= res_val;
      end
   end

   imuctf_div #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num_x  (ay_ff),
      .num_y  (ax_ff),
      .den    (az_ff),
      .busy   (div_busy),
      .quot_x (qx),
      .quot_y (qy)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {angle_y_ff, angle_x_ff};
   assign rsp_tuser  = zero_div_ff;

   a_start_at_top: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (seq_state_ff == SEQ_RUN && upc_ff == '0))
      else $error("accepted word did not start the program at step zero");

   a_post_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(seq_state_ff == SEQ_RUN && ucw.op == UOP_DONE))
      else $error("result posted outside the final step");

   a_quot_ready: assert property (@(posedge clock) disable iff (reset)
      (step_go && ucw.op == UOP_MLO && (ucw.a == RS_QX || ucw.a == RS_QY)) |-> !div_busy)
      else $error("quotient used while divider busy");

endmodule

>>> test/imu_complementary_tilt_filter_checker.sv
`timescale 1ns / 1ps

// Watch both streams, predict the filtered angles, compare each rsp word
module imu_complementary_tilt_filter_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   input  logic                                    req_tready,
   input  logic [imuctf_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   input  logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   input  logic [imuctf_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   input  logic [imuctf_pkg::RSP_USER_WIDTH-1:0]   rsp_tuser,
   input  logic                                    csr_we,
   input  logic [imuctf_pkg::CSR_ADDR_WIDTH-1:0]   csr_addr,
   input  logic [imuctf_pkg::CFG_WIDTH-1:0]        csr_wdata,
   output int                                      mismatch_count,
   output int                                      outstanding,
   output int                                      results_checked,
   output int                                      flagged_results
);

   import imuctf_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] angle_x;
      logic signed [FIELD_WIDTH-1:0] angle_y;
      logic                          zero_divisor;
   } angle_update_type;

   angle_update_type pending_angles[$];

   logic [CFG_WIDTH-1:0]          rad_to_deg_q;
   logic [GAIN_WIDTH-1:0]         gyro_step_q;
   logic [GAIN_WIDTH-1:0]         blend_q;
   logic [GAIN_WIDTH-1:0]         accel_weight_q;
   logic signed [FIELD_WIDTH-1:0] angle_x_q;
   logic signed [FIELD_WIDTH-1:0] angle_y_q;

   int fail_total = 0;
   int checked_total = 0;
   int flagged_total = 0;

   // floor(a*b / 2^FRAC) from the full product, wrapped to 32 bits
   function automatic logic signed [31:0] fix_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [63:0] wide_a;
      logic signed [63:0] wide_b;
      logic signed [63:0] prod;
      wide_a = a;
      wide_b = b;
      prod   = wide_a * wide_b;
      return prod[FRAC+31:FRAC];
   endfunction

   // (a * 2^FRAC) / b truncated toward zero, wrapped to 32 bits; b nonzero
   function automatic logic signed [31:0] fix_div(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic [63:0] mag_a;
      logic [63:0] mag_b;
      logic [63:0] quo;
      mag_a = {32'd0, (a[31] ? -a : a)};
      mag_b = {32'd0, (b[31] ? -b : b)};
      quo   = (mag_a << FRAC) / mag_b;
      if (a[31] != b[31])
         quo = -quo;
      return quo[31:0];
   endfunction

   // Small-angle tilt; saturate by the numerator's sign on a zero divisor
   function automatic logic signed [31:0] accel_tilt(input logic signed [31:0] num,
                                                     input logic signed [31:0] den,
                                                     input logic signed [31:0] r2d);
      if (den == 0) begin
         if (num == 0)
            return 32'sd0;
         return num[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return fix_mul(fix_div(num, den), r2d);
   endfunction

   function automatic angle_update_type next_angles(input logic [REQ_DATA_WIDTH-1:0] sample);
      logic signed [31:0] ax, ay, az, gx, gy;
      logic signed [31:0] r2d, step, keep, awgt;
      logic signed [31:0] tilt_x, tilt_y, turn_x, turn_y;
      angle_update_type   upd;
      ax     = sample[31:0];
      ay     = sample[63:32];
      az     = sample[95:64];
      gx     = sample[127:96];
      gy     = sample[159:128];
      r2d    = {10'd0, rad_to_deg_q};
      step   = {16'd0, gyro_step_q};
      keep   = {16'd0, blend_q};
      awgt   = {16'd0, accel_weight_q};
      tilt_x = accel_tilt(ay, az, r2d);
      tilt_y = accel_tilt(ax, az, r2d);
      turn_x = fix_mul(gx, step);
      turn_y = fix_mul(gy, step);
      upd.angle_x      = fix_mul(angle_x_q - turn_x, keep) - fix_mul(tilt_x, awgt);
      upd.angle_y      = fix_mul(angle_y_q + turn_y, keep) - fix_mul(tilt_y, awgt);
      upd.zero_divisor = (az == 0);
      return upd;
   endfunction

   always @(posedge clock) begin
      angle_update_type want;
      if (reset) begin
         rad_to_deg_q   = RST_RAD_TO_DEG;
         gyro_step_q    = RST_GYRO_STEP;
         blend_q        = RST_BLEND;
         accel_weight_q = RST_ACCEL_WEIGHT;
         angle_x_q      = '0;
         angle_y_q      = '0;
         pending_angles.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_RAD_TO_DEG:   rad_to_deg_q   = csr_wdata;
               CSR_GYRO_STEP:    gyro_step_q    = csr_wdata[GAIN_WIDTH-1:0];
               CSR_BLEND:        blend_q        = csr_wdata[GAIN_WIDTH-1:0];
               CSR_ACCEL_WEIGHT: accel_weight_q = csr_wdata[GAIN_WIDTH-1:0];
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            if (pending_angles.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%0t: unexpected rsp word x=%0d y=%0d flag=%0b", $realtime,
                           $signed(rsp_tdata[31:0]), $signed(rsp_tdata[63:32]),
                           rsp_tuser[0]);
            end else begin
               want = pending_angles.pop_front();
               checked_total++;
               if (rsp_tuser[0] === 1'b1)
                  flagged_total++;
               if (rsp_tdata[31:0] !== want.angle_x || rsp_tdata[63:32] !== want.angle_y ||
                   rsp_tuser[0] !== want.zero_divisor) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display("%0t: word %0d exp x=%0d y=%0d f=%0b, got x=%0d y=%0d f=%0b",
                              $realtime, checked_total, want.angle_x, want.angle_y,
                              want.zero_divisor, $signed(rsp_tdata[31:0]),
                              $signed(rsp_tdata[63:32]), rsp_tuser[0]);
               end
            end
         end

         if (req_tvalid && req_tready) begin
            want      = next_angles(req_tdata);
            angle_x_q = want.angle_x;
            angle_y_q = want.angle_y;
            pending_angles.push_back(want);
         end
      end

      mismatch_count  <= fail_total;
      outstanding     <= pending_angles.size();
      results_checked <= checked_total;
      flagged_results <= flagged_total;
   end

endmodule

>>> test/imu_complementary_tilt_filter_top_test.sv
`timescale 1ns / 1ps

module imu_complementary_tilt_filter_top_test;

   import imuctf_pkg::*;

   localparam int SETTING_PHASES  = 8;
   localparam int WORDS_PER_PHASE = 206;

   // Field corners and one g at 15 fraction bits
   localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] ONE_G = 32'sd32768;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_DATA_WIDTH-1:0]   req_tdata  = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]   rsp_tdata;
   logic [RSP_USER_WIDTH-1:0]   rsp_tuser;
   logic                        csr_we     = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0]   csr_addr   = '0;
   logic [CFG_WIDTH-1:0]        csr_wdata  = '0;

   int mismatch_count;
   int outstanding;
   int results_checked;
   int flagged_results;

   // Sender bookkeeping: words left in the current burst, valid currently held high
   int burst_left     = 0;
   bit sender_active  = 1'b0;
   int words_sent     = 0;
   int settings_used  = 1;

   // Receiver stall pattern state
   int stall_mode = 0;
   int mode_left  = 0;
   int hold_left  = 0;

   always begin
      #4;
      clock = 1'b1;
      #4;
      clock = 1'b0;
   end

   imu_complementary_tilt_filter_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   imu_complementary_tilt_filter_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .flagged_results (flagged_results)
   );

   // Receiver: switch at random between always ready, light random stalls, long
   // holds and coin-flip readiness, so the output register sits full across every
   // microstep of the next word
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(200, 2000);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: begin
               if (hold_left > 0) begin
                  hold_left--;
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
                  if ($urandom_range(0, 15) == 0)
                     hold_left = $urandom_range(1, 150);
               end
            end
            default: rsp_tready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   // Pack one sample, accel_x in the lowest bits
   function automatic logic [REQ_DATA_WIDTH-1:0] pack_sample(input logic signed [31:0] ax,
                                                              input logic signed [31:0] ay,
                                                              input logic signed [31:0] az,
                                                              input logic signed [31:0] gx,
                                                              input logic signed [31:0] gy);
      return {gy, gx, az, ay, ax};
   endfunction

   // Uniform value in [-lim, lim]
   function automatic logic signed [31:0] span(input int unsigned lim);
      return $urandom_range(0, 2 * lim) - lim;
   endfunction

   function automatic logic signed [31:0] corner_value();
      case ($urandom_range(0, 7))
         0:       return 32'sd0;
         1:       return 32'sd1;
         2:       return -32'sd1;
         3:       return S_MAX;
         4:       return S_MIN;
         5:       return ONE_G;
         6:       return -ONE_G;
         default: return 32'sd1 <<< $urandom_range(0, 31);
      endcase
   endfunction

   // Mostly plausible motion, then zero accel_z, full-range noise and corners
   function automatic logic [REQ_DATA_WIDTH-1:0] random_sample();
      int unsigned        kind;
      logic signed [31:0] ax, ay, az, gx, gy;
      kind = $urandom_range(0, 99);
      ax   = span(65536);
      ay   = span(65536);
      az   = span(8192) + ($urandom_range(0, 1) ? ONE_G : -ONE_G);
      gx   = span(8192000);
      gy   = span(8192000);
      if (kind < 55) begin
         if ($urandom_range(0, 9) == 0)
            az = span(64);
      end else if (kind < 70) begin
         // zero divisor: vary numerator sign, including zero numerators
         az = 32'sd0;
         case ($urandom_range(0, 3))
            0:       ax = 32'sd0;
            1:       ax = $urandom();
            default: ;
         endcase
         case ($urandom_range(0, 3))
            0:       ay = 32'sd0;
            1:       ay = $urandom();
            default: ;
         endcase
      end else if (kind < 90) begin
         ax = $urandom();
         ay = $urandom();
         az = $urandom();
         gx = $urandom();
         gy = $urandom();
      end else begin
         ax = corner_value();
         ay = corner_value();
         az = corner_value();
         gx = corner_value();
         gy = corner_value();
      end
      return pack_sample(ax, ay, az, gx, gy);
   endfunction

   // Offer one word and hold it until taken; at the end of a burst drop valid
   // for a random, nonzero gap
   task automatic send_sample(input logic [REQ_DATA_WIDTH-1:0] word);
      int gap;
      req_tvalid    <= 1'b1;
      req_tdata     <= word;
      sender_active  = 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid    <= 1'b0;
         sender_active  = 1'b0;
         case ($urandom_range(0, 9))
            6, 7:    gap = $urandom_range(1, 4);
            8:       gap = $urandom_range(70, 200);
            9:       gap = 1;
            default: gap = $urandom_range(1, 70);
         endcase
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 6);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off the sender until every expected word has come back
   task automatic wait_for_drain();
      if (sender_active) begin
         req_tvalid    <= 1'b0;
         sender_active  = 1'b0;
         @(posedge clock);
      end
      while (outstanding != 0)
         @(posedge clock);
      // the block returns to idle on the step that posts its result
      repeat (4) @(posedge clock);
   endtask

   // Write all four registers on back-to-back edges; block must be idle
   task automatic program_filter(input int phase);
      logic [CFG_WIDTH-1:0]  r2d;
      logic [GAIN_WIDTH-1:0] step, keep, awgt;
      case (phase)
         0: begin
            r2d  = RST_RAD_TO_DEG;
            step = RST_GYRO_STEP;
            keep = RST_BLEND;
            awgt = RST_ACCEL_WEIGHT;
         end
         1: begin
            r2d  = '0;
            step = '0;
            keep = '0;
            awgt = '0;
         end
         2: begin
            r2d  = 22'd4194303;
            step = 16'd32768;
            keep = 16'd32768;
            awgt = 16'd32768;
         end
         3: begin
            // full radian-to-degree scale, no accelerometer pull: pure gyro integration
            r2d  = 22'd4194303;
            step = 16'd1;
            keep = 16'd32768;
            awgt = '0;
         end
         default: begin
            r2d  = CFG_WIDTH'($urandom_range(0, 4194303));
            step = GAIN_WIDTH'($urandom_range(0, 32768));
            keep = GAIN_WIDTH'($urandom_range(0, 32768));
            awgt = GAIN_WIDTH'($urandom_range(0, 32768));
         end
      endcase
      csr_we    <= 1'b1;
      csr_addr  <= CSR_RAD_TO_DEG;
      csr_wdata <= r2d;
      @(posedge clock);
      csr_addr  <= CSR_GYRO_STEP;
      csr_wdata <= {6'd0, step};
      @(posedge clock);
      csr_addr  <= CSR_BLEND;
      csr_wdata <= {6'd0, keep};
      @(posedge clock);
      csr_addr  <= CSR_ACCEL_WEIGHT;
      csr_wdata <= {6'd0, awgt};
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int phase;
      int n;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset register values
      // zero divisor with zero numerators: both tilts 0
      send_sample(pack_sample(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
      // zero divisor, positive numerators: saturate high
      send_sample(pack_sample(ONE_G, 2 * ONE_G, 32'sd0, 32'sd0, 32'sd0));
      // zero divisor, negative numerators: saturate low
      send_sample(pack_sample(-ONE_G, -32'sd5, 32'sd0, 32'sd100, -32'sd100));
      // zero divisor, mixed signs with gyro extremes
      send_sample(pack_sample(S_MAX, S_MIN, 32'sd0, S_MAX, S_MIN));
      send_sample(pack_sample(S_MIN, 32'sd0, 32'sd0, S_MIN, S_MAX));
      // field extremes everywhere
      send_sample(pack_sample(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
      send_sample(pack_sample(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
      // quotients far past the working width wrap
      send_sample(pack_sample(S_MIN, S_MAX, -32'sd1, 32'sd0, 32'sd0));
      send_sample(pack_sample(S_MAX, S_MIN, 32'sd1, 32'sd0, 32'sd0));
      // level and tilted sensor, upright and inverted
      send_sample(pack_sample(32'sd1000, -32'sd2000, ONE_G, 32'sd65536, -32'sd65536));
      send_sample(pack_sample(-32'sd1000, 32'sd2000, -ONE_G, -32'sd65536, 32'sd65536));
      send_sample(pack_sample(ONE_G, ONE_G, ONE_G, 32'sd327680, 32'sd327680));
      send_sample(pack_sample(32'sd0, 32'sd0, -32'sd1, S_MAX, S_MAX));
      send_sample(pack_sample(32'sd0, 32'sd0, ONE_G, S_MIN, S_MIN));
      // tiny ratios that truncate toward zero
      send_sample(pack_sample(32'sd1, -32'sd1, S_MAX, 32'sd1, -32'sd1));
      send_sample(pack_sample(-32'sd1, 32'sd1, S_MIN, -32'sd1, 32'sd1));
      // alternating bit patterns on every field
      send_sample(pack_sample(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F,
                              32'shF0F0_F0F0, 32'sh3333_3333));
      send_sample(pack_sample(32'shAAAA_AAAA, 32'sh5555_5555, 32'shF0F0_F0F0,
                              32'sh0F0F_0F0F, 32'shCCCC_CCCC));

      // Random words under a sequence of register settings, reset values and extremes first;
      // drain before each reprogramming and now and then mid-phase
      for (phase = 0; phase < SETTING_PHASES; phase++) begin
         wait_for_drain();
         program_filter(phase);
         for (n = 0; n < WORDS_PER_PHASE; n++) begin
            send_sample(random_sample());
            if ($urandom_range(0, 199) == 0)
               wait_for_drain();
         end
      end

      // Let the last results land, then watch for strays
      wait_for_drain();
      repeat (200) @(posedge clock);

      $display("Sent %0d samples over %0d register settings; checked %0d results,",
               words_sent, settings_used, results_checked);
      $display("%0d of them with zero accel_z; %0d mismatches", flagged_results,
               mismatch_count);
      if (mismatch_count == 0 && outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Hang guard, several times the slowest legal run
   initial begin
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

>>> files.f
hdl/imuctf_pkg.sv
hdl/imuctf_div.sv
hdl/imu_complementary_tilt_filter_top.sv
test/imu_complementary_tilt_filter_checker.sv
test/imu_complementary_tilt_filter_top_test.sv
